FILE: sv/assert_macros.svh
// Assertion macros used by the sorter top level; they assume signals named clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/isrt_pkg.sv
// Package with the types and constants of the insertion sorter.
package isrt_pkg;

  localparam int KEY_W     = 32;
  localparam int TAG_W     = 16;
  localparam int DEPTH_DEF = 16;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_res;
    logic [TAG_W-1:0] tag_res;
    logic             last_res;
    logic             overflow;
  } res_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic insert;
    logic shift;
    logic descending;
  } cell_ctl_t;

endpackage

FILE: sv/insertion_sorter_top.sv
// Top level of the insertion sorter: a chain of record cells and its sequencer.
//
// The sorter keeps up to DEPTH records (a key and a tag) in a chain of cells,
// always in sorted order: ascending by unsigned key, or descending when the
// descending register is set. Each record transaction is broadcast to
// every cell; each cell compares the new key with its own, and in the same
// cycle the cells at and behind the insertion point move one place right
// while the new record drops into the gap. Equal keys keep arrival order.
// A record that is not marked last is therefore stored at its transaction,
// and the block takes a new one every cycle unless it is draining. When the
// store is full the record is dropped and the overflow flag of the set is
// raised. A record marked last is inserted the same way, and then the chain
// drains: cell 0 drives the result port, and each result transaction shifts
// the whole chain one place left, so held records leave one per result,
// with last_res on the final one. Input is stalled while the chain drains.
// The per-cycle critical path is the key compare in each cell followed by
// the insertion-point signal that ripples through the chain from the right.
// The single configuration register is written through a valid/ready port
// that is always ready; it is meant to be changed only while the block is
// idle.
module insertion_sorter_top
  import isrt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  output logic  res_valid,
  input  logic  res_stall,
  output res_t  res,
  input  logic  cfg_valid,
  output logic  cfg_ready,
  input  logic  cfg_data
);

  `include "assert_macros.svh"

  logic             draining;
  logic             dropped;
  logic             descending;
  logic             item_acc;
  logic             res_acc;
  logic             full;
  cell_ctl_t        ctl;
  rec_t             new_rec;
  rec_t             cell_rec   [DEPTH];
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_ins;

  assign cfg_ready  = 1'b1;
  assign item_stall = draining;
  assign item_acc   = item_valid & ~item_stall;
  assign res_valid  = draining;
  assign res_acc    = res_valid & ~res_stall;

  // The chain is full once its rightmost cell holds a record.
  assign full = cell_valid[DEPTH-1];

  assign new_rec.key = item.key;
  assign new_rec.tag = item.tag;

  assign ctl.insert     = item_acc & ~full;
  assign ctl.shift      = res_acc;
  assign ctl.descending = descending;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      descending <= cfg_data;
    end
  end

  // Draining starts after the last record is taken in and ends when the
  // final held record leaves; the overflow flag covers the whole set.
  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else begin
      if (item_acc && item.last) begin
        draining <= 1'b1;
      end else if (res_acc && !cell_valid[1]) begin
        draining <= 1'b0;
      end
      if (item_acc && full) begin
        dropped <= 1'b1;
      end else if (res_acc && !cell_valid[1]) begin
        dropped <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t left_rec;
    logic left_valid;
    logic left_ins;
    rec_t right_rec;
    logic right_valid;
    logic right_ins;

    if (i == 0) begin : g_head
      // The head sees a virtual occupied neighbor that is ahead of any key.
      assign left_rec   = new_rec;
      assign left_valid = 1'b1;
      assign left_ins   = 1'b0;
    end else begin : g_mid_l
      assign left_rec   = cell_rec[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_ins   = cell_ins[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_rec   = new_rec;
      assign right_valid = 1'b0;
      assign right_ins   = 1'b1;
    end else begin : g_mid_r
      assign right_rec   = cell_rec[i+1];
      assign right_valid = cell_valid[i+1];
      assign right_ins   = cell_ins[i+1];
    end

    isrt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_rec     (new_rec),
      .left_rec    (left_rec),
      .left_valid  (left_valid),
      .left_ins    (left_ins),
      .right_rec   (right_rec),
      .right_valid (right_valid),
      .right_ins   (right_ins),
      .rec         (cell_rec[i]),
      .valid       (cell_valid[i]),
      .ins         (cell_ins[i])
    );
  end

  assign res.key_res  = cell_rec[0].key;
  assign res.tag_res  = cell_rec[0].tag;
  assign res.last_res = ~cell_valid[1];
  assign res.overflow = dropped;

  // Occupied cells always form an unbroken run starting at cell 0.
  `ASSERT_IMPL(a_valid_prefix, 1'b1, ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
  // While draining, the head cell holds the record being offered.
  `ASSERT_IMPL(a_drain_head, draining, cell_valid[0])
  // A stored record grows the chain by exactly one cell.
  `ASSERT_NEXT(a_insert_grows, ctl.insert,
               $countones(cell_valid) == $countones($past(cell_valid)) + 1)
  // A last record always starts the drain in the next cycle.
  `ASSERT_NEXT(a_last_drains, item_acc && item.last, res_valid)

endmodule

FILE: sv/isrt_cell.sv
// One cell of the insertion chain: holds one record and its valid bit.
module isrt_cell
  import isrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  rec_t      new_rec,
  input  rec_t      left_rec,
  input  logic      left_valid,
  input  logic      left_ins,
  input  rec_t      right_rec,
  input  logic      right_valid,
  input  logic      right_ins,
  output rec_t      rec,
  output logic      valid,
  output logic      ins
);

  logic ahead;

  // The new key goes ahead of this cell's key (strict, so equal keys stay in order).
  always_comb begin
    if (ctl.descending) begin
      ahead = new_rec.key > rec.key;
    end else begin
      ahead = new_rec.key < rec.key;
    end
  end

  // This cell is at or behind the insertion point when it and every cell to
  // its right either is empty or holds a key the new one goes ahead of.
  assign ins = right_ins & (~valid | ahead);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= right_valid;
    end else if (ctl.insert) begin
      valid <= valid | left_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      rec <= right_rec;
    end else if (ctl.insert && ins) begin
      rec <= left_ins ? left_rec : new_rec;
    end
  end

endmodule

FILE: tb/insertion_sorter_top_test.sv
// Self-checking testbench of the insertion sorter: directed sets, random sets, output back-pressure.
module insertion_sorter_top_test;
  import isrt_pkg::*;

  // The chain holds this many records. The block is built with its default depth.
  localparam int CAPACITY = DEPTH_DEF;

  // Values of the order register.
  localparam bit ORDER_ASCENDING  = 1'b0;
  localparam bit ORDER_DESCENDING = 1'b1;

  // About this many records are sent after the directed part.
  localparam int RANDOM_ITEMS = 150;
  // The random set during which the receiver holds off for a long stretch.
  localparam int PRESSURE_PHASE = 3;
  localparam int PRESSURE_HOLD  = 80;
  // Cycles allowed for the chain to settle after its last result before the
  // register is written.
  localparam int SETTLE_CYCLES = 4;
  // Cycles that pass after the final result before the verdict.
  localparam int TAIL_CYCLES = 24;
  // Cycles without any transaction on any channel before the run is abandoned.
  localparam int STALL_LIMIT = 1000;

  // Kinds of rows in the directed table.
  typedef enum {ROW_RECORD, ROW_ORDER} row_kind_t;

  // One row of the directed table. A row either writes the order register or
  // sends one record; where the result is obvious it is typed in as well.
  typedef struct {
    row_kind_t kind;
    bit        order;
    item_t     rec;
    bit        known;
    res_t      want;
  } plan_row_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  item_valid;
  logic  item_stall;
  item_t item;
  logic  res_valid;
  logic  res_stall;
  res_t  res;
  logic  cfg_valid;
  logic  cfg_ready;
  logic  cfg_data;

  // Shadow of the block: the held records in sorted order, the dropped flag of
  // the current set and the order register.
  rec_t shadow_store[$];
  bit   shadow_dropped;
  bit   order_desc;

  // Results predicted but not yet seen on the result port, oldest first.
  res_t sorted_out[$];

  plan_row_t directed_plan[$];

  int  mismatches;
  int  idle_cycles;
  // Set when both sides should run without gaps for the current set.
  bit  steady_phase;
  // Asks the receiver for one long hold-off at its next result.
  bit  hold_request;

  insertion_sorter_top DUT (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // True when a new key has to stand in front of a held key. Equal keys never
  // pass each other, which is what keeps the sort stable.
  function automatic bit precedes(logic [KEY_W-1:0] fresh_key, logic [KEY_W-1:0] held_key);
    return order_desc ? (fresh_key > held_key) : (fresh_key < held_key);
  endfunction

  // Inserts one accepted record into the shadow store. For a record marked
  // last, the whole held set comes back in order and the store is emptied. A
  // record that finds the store full is lost and the set is flagged.
  task automatic predict_record(input item_t it, output res_t outs[$]);
    rec_t fresh;
    res_t r;
    int   pos;
    outs = {};
    fresh.key = it.key;
    fresh.tag = it.tag;
    if (shadow_store.size() >= CAPACITY) begin
      shadow_dropped = 1'b1;
    end else begin
      pos = shadow_store.size();
      while (pos > 0 && precedes(fresh.key, shadow_store[pos-1].key)) pos--;
      shadow_store.insert(pos, fresh);
    end
    if (it.last) begin
      foreach (shadow_store[i]) begin
        r.key_res  = shadow_store[i].key;
        r.tag_res  = shadow_store[i].tag;
        r.last_res = (i == shadow_store.size() - 1);
        r.overflow = shadow_dropped;
        outs.push_back(r);
      end
      shadow_store   = {};
      shadow_dropped = 1'b0;
    end
  endtask

  // Offers one record after a random gap, waits for its transaction and then
  // queues the results it causes. A row with a typed-in result queues that
  // one instead of the predicted one; the shadow state moves on either way.
  task automatic send_record(input item_t it, input bit known, input res_t want);
    int unsigned gap;
    res_t        outs[$];
    gap = steady_phase ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    // The transaction takes place at the first edge at which stall is low.
    do @(posedge clk); while (item_stall);
    predict_record(it, outs);
    if (known) begin
      sorted_out.push_back(want);
    end else begin
      foreach (outs[i]) sorted_out.push_back(outs[i]);
    end
  endtask

  // Writes the order register once the block is idle: every predicted result
  // has been taken and the chain has had time to settle.
  task automatic set_order(input bit descending);
    item_valid <= 1'b0;
    while (sorted_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= descending;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    order_desc = descending;
  endtask

  task automatic add_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                            input bit last);
    plan_row_t row;
    row.kind     = ROW_RECORD;
    row.order    = ORDER_ASCENDING;
    row.rec.key  = key;
    row.rec.tag  = tag;
    row.rec.last = last;
    row.known    = 1'b0;
    row.want     = '0;
    directed_plan.push_back(row);
  endtask

  // A one-record set whose single result is written out in full.
  task automatic add_known(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                           input logic [KEY_W-1:0] want_key,
                           input logic [TAG_W-1:0] want_tag,
                           input bit want_last, input bit want_overflow);
    add_record(key, tag, 1'b1);
    directed_plan[$].known         = 1'b1;
    directed_plan[$].want.key_res  = want_key;
    directed_plan[$].want.tag_res  = want_tag;
    directed_plan[$].want.last_res = want_last;
    directed_plan[$].want.overflow = want_overflow;
  endtask

  task automatic add_order(input bit descending);
    plan_row_t row;
    row.kind  = ROW_ORDER;
    row.order = descending;
    row.rec   = '0;
    row.known = 1'b0;
    row.want  = '0;
    directed_plan.push_back(row);
  endtask

  // Compares one result transaction with the oldest prediction.
  task automatic check_result(input res_t got);
    res_t want;
    if (sorted_out.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected result: key %h tag %h last %b overflow %b",
                 got.key_res, got.tag_res, got.last_res, got.overflow);
      mismatches++;
    end else begin
      want = sorted_out.pop_front();
      if (got.key_res !== want.key_res || got.tag_res !== want.tag_res ||
          got.last_res !== want.last_res || got.overflow !== want.overflow) begin
        if (mismatches < 10)
          $display({"result mismatch: expected key %h tag %h last %b overflow %b, ",
                    "got key %h tag %h last %b overflow %b"},
                   want.key_res, want.tag_res, want.last_res, want.overflow,
                   got.key_res, got.tag_res, got.last_res, got.overflow);
        mismatches++;
      end
    end
  endtask

  // Receiver. Before each result it holds stall high for a random number of
  // cycles, unless the current set runs without gaps. Once during the run it
  // holds off for a long stretch in the middle of a large set, so that the
  // chain stays full and the sender, which keeps offering the next set, is
  // stalled at the input.
  initial begin
    int unsigned gap;
    res_stall <= 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        res_stall <= 1'b1;
        do @(posedge clk); while (!res_valid);
        repeat (PRESSURE_HOLD) @(posedge clk);
      end else begin
        gap = steady_phase ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
          res_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
      end
      res_stall <= 1'b0;
      // Outputs are read as they stood just before the edge of the transaction.
      do @(posedge clk); while (!res_valid);
      check_result(res);
    end
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((item_valid && !item_stall) || (res_valid && !res_stall) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("insertion_sorter_top regression: fail");
        $finish;
      end
    end
  end

  // Stimulus: reset, the directed table, then random sets, then the verdict.
  initial begin
    item_t       it;
    res_t        none;
    int unsigned set_size;
    int unsigned sent;
    int          phase;
    bit          pressure;
    bit          after_pressure;

    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= ORDER_ASCENDING;
    mismatches     = 0;
    order_desc     = ORDER_ASCENDING;
    shadow_dropped = 1'b0;
    steady_phase   = 1'b0;
    hold_request   = 1'b0;
    none           = '0;

    // Single-record sets right after reset come back unchanged and marked
    // last: the largest and the smallest key and tag.
    add_known(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0);
    add_known(32'h0000_0000, 16'h0000, 32'h0000_0000, 16'h0000, 1'b1, 1'b0);
    // Equal keys in ascending order: the first five must leave before the second.
    add_record(32'd5, 16'h00A1, 1'b0);
    add_record(32'd3, 16'h00B2, 1'b0);
    add_record(32'd5, 16'h00C3, 1'b1);
    // The same pattern in descending order.
    add_order(ORDER_DESCENDING);
    add_record(32'd5, 16'h0001, 1'b0);
    add_record(32'd9, 16'h0002, 1'b0);
    add_record(32'd5, 16'h0003, 1'b1);
    // Fill the store, lose one plain record, then lose the record marked last
    // as well: the full store drains with the overflow flag on every result.
    for (int i = 0; i < CAPACITY; i++)
      add_record(32'h1000_0000 * i + i, 16'hF000 | 16'(i), 1'b0);
    add_record(32'h8000_0000, 16'h5A5A, 1'b0);
    add_record(32'hFFFF_FFFF, 16'hA5A5, 1'b1);
    add_order(ORDER_ASCENDING);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_ORDER)
        set_order(directed_plan[r].order);
      else
        send_record(directed_plan[r].rec, directed_plan[r].known, directed_plan[r].want);
    end

    // Random sets. Most are short, some fill the chain, a few overrun it.
    // Keys come from the whole range, from a narrow range that makes ties
    // likely, and from both ends. The order register changes between sets.
    sent           = 0;
    phase          = 0;
    after_pressure = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      pressure = (phase == PRESSURE_PHASE);
      // The set after the long hold-off keeps its order so that its records
      // are already waiting at the input while the chain cannot drain.
      if (!pressure && !after_pressure && $urandom_range(0, 2) == 0)
        set_order($urandom_range(0, 1) ? ORDER_DESCENDING : ORDER_ASCENDING);
      after_pressure = pressure;
      steady_phase   = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 19))
        17:      set_size = CAPACITY;
        18, 19:  set_size = $urandom_range(CAPACITY + 1, CAPACITY + 4);
        14, 15, 16: set_size = $urandom_range(7, CAPACITY - 1);
        default: set_size = $urandom_range(1, 6);
      endcase
      if (pressure) begin
        set_size     = CAPACITY;
        hold_request = 1'b1;
      end
      for (int unsigned j = 0; j < set_size; j++) begin
        case ($urandom_range(0, 9))
          4, 5, 6: it.key = $urandom_range(0, 7);
          7:       it.key = '0;
          8:       it.key = '1;
          9:       it.key = 32'hFFFF_FFF8 + $urandom_range(0, 7);
          default: it.key = $urandom;
        endcase
        it.tag  = 16'($urandom_range(0, 16'hFFFF));
        it.last = (j == set_size - 1);
        send_record(it, 1'b0, none);
        sent++;
      end
      phase++;
    end
    item_valid <= 1'b0;

    // Wait for every predicted result, then give the block time to show any
    // result that should not be there.
    while (sorted_out.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && sorted_out.size() == 0)
      $display("insertion_sorter_top regression: pass");
    else
      $display("insertion_sorter_top regression: fail");
    $finish;
  end

endmodule
